>>> hdl/mkrs_pkg.sv
// Shared types, codes and key function of the multikey rank-select table.
package mkrs_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 64;

   localparam int RARITY_W = 3;
   localparam int LEVEL_W  = 8;
   localparam int TIME_W   = 32;
   localparam int ID_W     = 32;
   localparam int RANK_W   = 6;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 6;
   localparam int KEY_W    = RARITY_W + LEVEL_W + TIME_W + ID_W;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   localparam logic [MODE_W-1:0] MODE_RARITY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LEVEL  = 2'd2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   typedef struct packed {
      logic [RARITY_W-1:0] rarity;
      logic [LEVEL_W-1:0]  level;
      logic [TIME_W-1:0]   capture_time;
      logic [ID_W-1:0]     record_id;
   } rec_type;

   typedef struct packed {
      logic              command;
      rec_type           rec;
      logic [RANK_W-1:0] rank;
      logic [MODE_W-1:0] key_mode;
   } req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_NEXT,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      RES_INS_OK,
      RES_FULL,
      RES_RANGE,
      RES_QUERY
   } res_kind_type;

   typedef struct packed {
      logic         capture;
      logic         write_rec;
      logic         set_res;
      res_kind_type res_kind;
      logic         scan_init;
      logic         scan_run;
      logic         next_pick;
      logic         load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_query;
      logic full;
      logic rank_oob;
      logic pass_done;
      logic last_pick;
      logic rsp_free;
   } ctrl_stat_type;

   // Descending sort key; larger compares first. Time mode keeps only the tie-breaks.
   function automatic logic [KEY_W-1:0] make_key(input logic [MODE_W-1:0] mode,
                                                 input rec_type r);
      logic [KEY_W-1:0] k;
      unique case (mode)
         MODE_RARITY: k = {r.rarity, r.level, r.capture_time, r.record_id};
         MODE_LEVEL:  k = {r.level, r.rarity, r.capture_time, r.record_id};
         default:     k = {{(RARITY_W + LEVEL_W){1'b0}}, r.capture_time, r.record_id};
      endcase
      return k;
   endfunction

endpackage

>>> hdl/mkrs_ctrl.sv
// Sequencer of the rank-select table: decode, scan passes and result handoff.
module mkrs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  mkrs_pkg::ctrl_stat_type stat,
   output mkrs_pkg::ctrl_cmd_type  cmd
);

   mkrs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mkrs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mkrs_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = mkrs_pkg::ST_DECODE;
         end
         mkrs_pkg::ST_DECODE: begin
            if (stat.is_query && !stat.rank_oob) state_in = mkrs_pkg::ST_SCAN;
            else state_in = mkrs_pkg::ST_RESULT;
         end
         mkrs_pkg::ST_SCAN: begin
            if (stat.pass_done) state_in = mkrs_pkg::ST_NEXT;
         end
         mkrs_pkg::ST_NEXT: begin
            if (stat.last_pick) state_in = mkrs_pkg::ST_RESULT;
            else state_in = mkrs_pkg::ST_SCAN;
         end
         mkrs_pkg::ST_RESULT: begin
            if (stat.rsp_free) state_in = mkrs_pkg::ST_IDLE;
         end
         default: state_in = mkrs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.res_kind = mkrs_pkg::RES_INS_OK;
      req_tready = 1'b0;
      unique case (state_ff)
         mkrs_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         mkrs_pkg::ST_DECODE: begin
            if (!stat.is_query) begin
               cmd.set_res = 1'b1;
               if (stat.full) begin
                  cmd.res_kind = mkrs_pkg::RES_FULL;
               end else begin
                  cmd.write_rec = 1'b1;
                  cmd.res_kind  = mkrs_pkg::RES_INS_OK;
               end
            end else if (stat.rank_oob) begin
               cmd.set_res  = 1'b1;
               cmd.res_kind = mkrs_pkg::RES_RANGE;
            end else begin
               cmd.scan_init = 1'b1;
            end
         end
         mkrs_pkg::ST_SCAN: begin
            cmd.scan_run = 1'b1;
         end
         mkrs_pkg::ST_NEXT: begin
            if (stat.last_pick) begin
               cmd.set_res  = 1'b1;
               cmd.res_kind = mkrs_pkg::RES_QUERY;
            end else begin
               cmd.next_pick = 1'b1;
            end
         end
         mkrs_pkg::ST_RESULT: begin
            cmd.load_rsp = stat.rsp_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

>>> hdl/mkrs_datapath.sv
// Record memory, selection scan, result and output registers.
module mkrs_datapath #(
   parameter int TABLE_DEPTH = mkrs_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mkrs_pkg::req_type               req,
   input  mkrs_pkg::ctrl_cmd_type          cmd,
   output mkrs_pkg::ctrl_stat_type         stat,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mkrs_pkg::STATUS_W-1:0]   rsp_status,
   output logic [mkrs_pkg::INDEX_W-1:0]    rsp_index,
   output logic [mkrs_pkg::ID_W-1:0]       rsp_id
);

   localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW  = $clog2(TABLE_DEPTH + 1);
   localparam int RW  = (CW > mkrs_pkg::RANK_W) ? CW : mkrs_pkg::RANK_W;
   localparam int FKW = mkrs_pkg::KEY_W + IW;
   localparam int XW  = IW + mkrs_pkg::INDEX_W;

   mkrs_pkg::rec_type mem [TABLE_DEPTH];

   mkrs_pkg::req_type req_ff;
   logic [CW-1:0]     count_ff, count_in;

   logic [CW-1:0]      addr_ff, addr_in;
   logic               rd_valid_ff;
   logic [IW-1:0]      rd_idx_ff;
   mkrs_pkg::rec_type  rd_rec_ff;
   logic               have_ff, have_in;
   logic               first_ff, first_in;
   logic [FKW-1:0]     best_key_ff, best_key_in;
   logic [IW-1:0]      best_idx_ff, best_idx_in;
   logic [mkrs_pkg::ID_W-1:0] best_id_ff, best_id_in;
   logic [FKW-1:0]     prev_key_ff, prev_key_in;
   logic [mkrs_pkg::RANK_W-1:0] pick_ff, pick_in;

   logic [mkrs_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [mkrs_pkg::INDEX_W-1:0]  res_index_ff, res_index_in;
   logic [mkrs_pkg::ID_W-1:0]     res_id_ff, res_id_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mkrs_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [mkrs_pkg::INDEX_W-1:0]  rsp_index_ff;
   logic [mkrs_pkg::ID_W-1:0]     rsp_id_ff;

   logic           issue;
   logic [FKW-1:0] cand_key;
   logic           take;
   logic [XW-1:0]  best_idx_x, slot_x;

   assign issue    = cmd.scan_run && (addr_ff < count_ff);
   // Lower slot wins among fully equal records, so the inverted slot is the last key.
   assign cand_key = {mkrs_pkg::make_key(req_ff.key_mode, rd_rec_ff), ~rd_idx_ff};
   assign take     = rd_valid_ff && (first_ff || (prev_key_ff > cand_key))
                     && (!have_ff || (cand_key > best_key_ff));

   assign best_idx_x = {{mkrs_pkg::INDEX_W{1'b0}}, best_idx_ff};
   assign slot_x     = {{mkrs_pkg::INDEX_W{1'b0}}, count_ff[IW-1:0]};

   always_comb begin
      stat.is_query  = (req_ff.command == mkrs_pkg::CMD_QUERY);
      stat.full      = (count_ff == CW'(TABLE_DEPTH));
      stat.rank_oob  = (RW'(req_ff.rank) >= RW'(count_ff));
      stat.pass_done = (addr_ff == count_ff) && !rd_valid_ff;
      stat.last_pick = (pick_ff == req_ff.rank);
      stat.rsp_free  = !rsp_valid_ff || rsp_tready;
   end

   // Memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.write_rec) mem[count_ff[IW-1:0]] <= req_ff.rec;
      if (issue) rd_rec_ff <= mem[addr_ff[IW-1:0]];
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.write_rec) count_in = count_ff + CW'(1);
   end

   always_comb begin
      addr_in     = addr_ff;
      have_in     = have_ff;
      first_in    = first_ff;
      best_key_in = best_key_ff;
      best_idx_in = best_idx_ff;
      best_id_in  = best_id_ff;
      prev_key_in = prev_key_ff;
      pick_in     = pick_ff;
      priority if (cmd.scan_init) begin
         addr_in  = '0;
         have_in  = 1'b0;
         first_in = 1'b1;
         pick_in  = '0;
      end else if (cmd.next_pick) begin
         addr_in     = '0;
         have_in     = 1'b0;
         first_in    = 1'b0;
         prev_key_in = best_key_ff;
         pick_in     = pick_ff + mkrs_pkg::RANK_W'(1);
      end else begin
         if (issue) addr_in = addr_ff + CW'(1);
         if (take) begin
            have_in     = 1'b1;
            best_key_in = cand_key;
            best_idx_in = rd_idx_ff;
            best_id_in  = rd_rec_ff.record_id;
         end
      end
   end

   always_comb begin
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_id_in     = res_id_ff;
      if (cmd.set_res) begin
         res_index_in = '0;
         res_id_in    = '0;
         unique case (cmd.res_kind)
            mkrs_pkg::RES_INS_OK: begin
               res_status_in = mkrs_pkg::STATUS_OK;
               res_index_in  = slot_x[mkrs_pkg::INDEX_W-1:0];
            end
            mkrs_pkg::RES_FULL:  res_status_in = mkrs_pkg::STATUS_FULL;
            mkrs_pkg::RES_RANGE: res_status_in = mkrs_pkg::STATUS_RANGE;
            mkrs_pkg::RES_QUERY: begin
               res_status_in = mkrs_pkg::STATUS_OK;
               res_index_in  = best_idx_x[mkrs_pkg::INDEX_W-1:0];
               res_id_in     = best_id_ff;
            end
            default: res_status_in = mkrs_pkg::STATUS_OK;
         endcase
      end
   end

   always_comb begin
      priority if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_valid_ff  <= issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req;
      if (issue) rd_idx_ff <= addr_ff[IW-1:0];
      addr_ff     <= addr_in;
      have_ff     <= have_in;
      first_ff    <= first_in;
      best_key_ff <= best_key_in;
      best_idx_ff <= best_idx_in;
      best_id_ff  <= best_id_in;
      prev_key_ff <= prev_key_in;
      pick_ff     <= pick_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_id_ff     <= res_id_in;
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_index_ff  <= res_index_ff;
         rsp_id_ff     <= res_id_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_id     = rsp_id_ff;

endmodule

>>> hdl/multikey_rank_select_table.sv
// Top level of the multikey rank-select table.
// Usage:
//  - req channel carries one command per transaction: insert appends a record to the
//    next free slot, query asks for the record at a zero-based rank in descending order
//    under the given key mode. rsp channel returns one transaction per command:
//    status, slot index and record id.
//  - One command is worked at a time; req_tready is high only while the sequencer idles.
//    A finished result sits in the output register, so the next command can be taken
//    while the receiver stalls; that command then waits in its last step for the slot.
//  - Insert and any rejected command go from decode to the result step; rsp_tvalid rises
//    as the sequencer returns to idle, where the next command can be accepted.
//  - Query: (rank + 1) selection passes, each reading all stored records through the
//    single read port of the record memory, one record per cycle, and then draining the
//    read pipeline before the next pass or the result step.
//  - Reset clears the record count and the handshake state only; the record memory is
//    not swept and slots above the count are never read. No wait after reset.
module multikey_rank_select_table #(
   parameter int TABLE_DEPTH = mkrs_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rarity[2:0], level[10:3], capture_time[42:11], record_id[74:43], rank[80:75],
   // key_mode[82:81], zero pad[87:83]
   input  logic [87:0] req_tdata,
   // command[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // entry_index[5:0], selected_id[37:6], zero pad[39:38]
   output logic [39:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]  rsp_tuser
);

   mkrs_pkg::req_type       req;
   mkrs_pkg::ctrl_cmd_type  cmd;
   mkrs_pkg::ctrl_stat_type stat;
   logic [mkrs_pkg::STATUS_W-1:0] rsp_status;
   logic [mkrs_pkg::INDEX_W-1:0]  rsp_index;
   logic [mkrs_pkg::ID_W-1:0]     rsp_id;

   always_comb begin
      req.command          = req_tuser[0];
      req.rec.rarity       = req_tdata[2:0];
      req.rec.level        = req_tdata[10:3];
      req.rec.capture_time = req_tdata[42:11];
      req.rec.record_id    = req_tdata[74:43];
      req.rank             = req_tdata[80:75];
      req.key_mode         = req_tdata[82:81];
   end

   mkrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mkrs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_index  (rsp_index),
      .rsp_id     (rsp_id)
   );

   assign rsp_tdata = {2'b00, rsp_id, rsp_index};
   assign rsp_tuser = rsp_status;

endmodule

>>> hdl/mkrs_checker.sv
// Port-level checks of the rank-select table, bound to the top level.
module mkrs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second command taken while one is in work");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == mkrs_pkg::STATUS_OK) || (rsp_tuser == mkrs_pkg::STATUS_FULL)
                     || (rsp_tuser == mkrs_pkg::STATUS_RANGE))
      else $error("undefined status code");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != mkrs_pkg::STATUS_OK) |-> rsp_tdata == '0)
      else $error("rejected command returned nonzero data");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("response appeared without a command in work");

endmodule

bind multikey_rank_select_table mkrs_checker u_mkrs_checker (.*);

>>> bench/tb.sv
// Self-checking bench for the multikey rank-select table: directed rows, then random traffic.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS  = mkrs_pkg::TABLE_DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1626;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 20000;
   localparam int IDLE_PCT     = 15;

   // modes without a package constant; the spare code sorts like time mode
   localparam logic [mkrs_pkg::MODE_W-1:0] MODE_TIME  = 2'd0;
   localparam logic [mkrs_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic [mkrs_pkg::STATUS_W-1:0] status;
      logic [mkrs_pkg::INDEX_W-1:0]  entry_index;
      logic [mkrs_pkg::ID_W-1:0]     selected_id;
   } table_reply_type;

   typedef struct packed {
      mkrs_pkg::req_type cmd;
      logic              typed;
      table_reply_type   reply;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   // predictor state
   mkrs_pkg::rec_type slot_rec [TABLE_SLOTS];
   int                stored_count = 0;
   table_reply_type   pending_replies [$];
   script_row_type    directed_rows [$];

   int mismatches   = 0;
   bit quiet        = 1'b0;
   bit hold_request = 1'b0;
   int hold_left    = 0;

   multikey_rank_select_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // true when slot a sorts strictly ahead of slot b
   function automatic bit outranks(int a, int b, logic [mkrs_pkg::MODE_W-1:0] mode);
      mkrs_pkg::rec_type x;
      mkrs_pkg::rec_type y;
      x = slot_rec[a];
      y = slot_rec[b];
      if (mode == mkrs_pkg::MODE_RARITY || mode == mkrs_pkg::MODE_LEVEL) begin
         if (mode == mkrs_pkg::MODE_RARITY && x.rarity != y.rarity) return x.rarity > y.rarity;
         if (x.level != y.level) return x.level > y.level;
         if (x.rarity != y.rarity) return x.rarity > y.rarity;
      end
      if (x.capture_time != y.capture_time) return x.capture_time > y.capture_time;
      if (x.record_id != y.record_id) return x.record_id > y.record_id;
      return 1'b0;
   endfunction

   function automatic table_reply_type apply_command(mkrs_pkg::req_type c);
      table_reply_type r;
      int place;
      r = '0;
      if (c.command == mkrs_pkg::CMD_INSERT) begin
         if (stored_count >= TABLE_SLOTS) begin
            r.status = mkrs_pkg::STATUS_FULL;
         end else begin
            slot_rec[stored_count] = c.rec;
            r.entry_index = mkrs_pkg::INDEX_W'(stored_count);
            stored_count++;
         end
      end else if (int'(c.rank) >= stored_count) begin
         r.status = mkrs_pkg::STATUS_RANGE;
      end else begin
         // position = records ahead of it, equal records in lower slots included
         for (int i = 0; i < stored_count; i++) begin
            place = 0;
            for (int j = 0; j < stored_count; j++)
               if (outranks(j, i, c.key_mode) || (j < i && !outranks(i, j, c.key_mode)))
                  place++;
            if (place == int'(c.rank)) begin
               r.entry_index = mkrs_pkg::INDEX_W'(i);
               r.selected_id = slot_rec[i].record_id;
            end
         end
      end
      return r;
   endfunction

   function automatic mkrs_pkg::req_type insert_cmd(logic [mkrs_pkg::RARITY_W-1:0] rarity,
                                                    logic [mkrs_pkg::LEVEL_W-1:0] level,
                                                    logic [mkrs_pkg::TIME_W-1:0] stamp,
                                                    logic [mkrs_pkg::ID_W-1:0] id);
      mkrs_pkg::req_type c;
      c = '0;
      c.command = mkrs_pkg::CMD_INSERT;
      c.rec = '{rarity, level, stamp, id};
      return c;
   endfunction

   function automatic mkrs_pkg::req_type rank_cmd(logic [mkrs_pkg::RANK_W-1:0] rank,
                                                  logic [mkrs_pkg::MODE_W-1:0] mode);
      mkrs_pkg::req_type c;
      c = '0;
      c.command = mkrs_pkg::CMD_QUERY;
      c.rank = rank;
      c.key_mode = mode;
      return c;
   endfunction

   task automatic add_row(mkrs_pkg::req_type c, bit typed,
                          logic [mkrs_pkg::STATUS_W-1:0] status,
                          logic [mkrs_pkg::INDEX_W-1:0] index,
                          logic [mkrs_pkg::ID_W-1:0] id);
      directed_rows.push_back('{c, typed, '{status, index, id}});
   endtask

   function automatic mkrs_pkg::req_type random_command();
      mkrs_pkg::req_type c;
      int pick;
      int v;
      c.rec.rarity = mkrs_pkg::RARITY_W'($urandom_range(0, 7));
      c.rec.level = mkrs_pkg::LEVEL_W'($urandom_range(0, 255));
      c.rec.capture_time = $urandom;
      c.rec.record_id = $urandom;
      c.rank = mkrs_pkg::RANK_W'($urandom_range(0, 63));
      c.key_mode = mkrs_pkg::MODE_W'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      c.command = (pick < ((stored_count < TABLE_SLOTS) ? 15 : 8)) ? mkrs_pkg::CMD_INSERT
                                                                  : mkrs_pkg::CMD_QUERY;
      if (c.command == mkrs_pkg::CMD_INSERT) begin
         if (stored_count > 0 && $urandom_range(0, 15) == 0) begin
            c.rec = slot_rec[$urandom_range(0, stored_count - 1)];
         end else begin
            // narrow pools (level and time half the time, id a quarter) so keys collide and tie-breaks matter
            if ($urandom_range(0, 1) == 0)
               c.rec.level = mkrs_pkg::LEVEL_W'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 0) c.rec.capture_time = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0) c.rec.record_id = $urandom_range(0, 7);
         end
      end else begin
         // ranks stay low on most queries: a pick costs a full scan of the table
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            v = $urandom_range(0, 63);
         end else if (pick < 8) begin
            v = (stored_count == 0) ? 0 : stored_count - 1 + int'($urandom_range(0, 1));
            if (v > 63) v = 63;
         end else begin
            v = $urandom_range(0, 7);
         end
         c.rank = mkrs_pkg::RANK_W'(v);
      end
      return c;
   endfunction

   task automatic offer(mkrs_pkg::req_type c, bit typed, table_reply_type typed_reply);
      table_reply_type want;
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, c.key_mode, c.rank, c.rec.record_id, c.rec.capture_time,
                    c.rec.level, c.rec.rarity};
      req_tuser <= c.command;
      do @(posedge clock); while (!req_tready);
      want = apply_command(c);
      pending_replies.push_back(typed ? typed_reply : want);
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t ns: %s got 0x%0h, want 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic check_reply(table_reply_type got);
      table_reply_type want;
      if (pending_replies.size() == 0) begin
         report_mismatch("unexpected rsp transaction, id", got.selected_id, 32'd0);
         return;
      end
      want = pending_replies.pop_front();
      if (got.status != want.status)
         report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.entry_index != want.entry_index)
         report_mismatch("entry_index", 32'(got.entry_index), 32'(want.entry_index));
      if (got.selected_id != want.selected_id)
         report_mismatch("selected_id", got.selected_id, want.selected_id);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_reply({rsp_tuser, rsp_tdata[5:0], rsp_tdata[37:6]});
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   initial begin
      int idle_run;
      idle_run = 0;
      while (idle_run < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_run = 0;
         else idle_run++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      // empty table, then a spread of records including an exact duplicate
      add_row(rank_cmd(0, MODE_TIME), 1'b1, mkrs_pkg::STATUS_RANGE, 0, 0);
      add_row(insert_cmd(0, 0, 0, 0), 1'b1, mkrs_pkg::STATUS_OK, 0, 0);
      add_row(insert_cmd(7, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
              mkrs_pkg::STATUS_OK, 1, 0);
      add_row(insert_cmd(4, 10, 100, 5), 1'b1, mkrs_pkg::STATUS_OK, 2, 0);
      add_row(insert_cmd(4, 10, 100, 5), 1'b1, mkrs_pkg::STATUS_OK, 3, 0);
      add_row(insert_cmd(4, 200, 50, 7), 1'b1, mkrs_pkg::STATUS_OK, 4, 0);
      add_row(insert_cmd(5, 200, 100, 9), 1'b1, mkrs_pkg::STATUS_OK, 5, 0);
      add_row(insert_cmd(2, 10, 100, 6), 1'b1, mkrs_pkg::STATUS_OK, 6, 0);
      add_row(rank_cmd(0, MODE_TIME), 1'b1, mkrs_pkg::STATUS_OK, 1, 32'hFFFF_FFFF);
      add_row(rank_cmd(6, MODE_TIME), 1'b1, mkrs_pkg::STATUS_OK, 0, 0);
      add_row(rank_cmd(7, mkrs_pkg::MODE_RARITY), 1'b1, mkrs_pkg::STATUS_RANGE, 0, 0);
      add_row(rank_cmd(63, mkrs_pkg::MODE_LEVEL), 1'b1, mkrs_pkg::STATUS_RANGE, 0, 0);
      add_row(rank_cmd(2, MODE_TIME), 1'b0, mkrs_pkg::STATUS_OK, 0, 0);
      add_row(rank_cmd(3, MODE_TIME), 1'b0, mkrs_pkg::STATUS_OK, 0, 0);
      add_row(rank_cmd(4, MODE_TIME), 1'b0, mkrs_pkg::STATUS_OK, 0, 0);
      add_row(rank_cmd(1, mkrs_pkg::MODE_RARITY), 1'b0, mkrs_pkg::STATUS_OK, 0, 0);
      add_row(rank_cmd(2, mkrs_pkg::MODE_RARITY), 1'b0, mkrs_pkg::STATUS_OK, 0, 0);
      add_row(rank_cmd(3, mkrs_pkg::MODE_RARITY), 1'b0, mkrs_pkg::STATUS_OK, 0, 0);
      add_row(rank_cmd(6, mkrs_pkg::MODE_RARITY), 1'b0, mkrs_pkg::STATUS_OK, 0, 0);
      add_row(rank_cmd(1, mkrs_pkg::MODE_LEVEL), 1'b0, mkrs_pkg::STATUS_OK, 0, 0);
      add_row(rank_cmd(2, mkrs_pkg::MODE_LEVEL), 1'b0, mkrs_pkg::STATUS_OK, 0, 0);
      add_row(rank_cmd(5, mkrs_pkg::MODE_LEVEL), 1'b0, mkrs_pkg::STATUS_OK, 0, 0);
      add_row(rank_cmd(1, MODE_SPARE), 1'b0, mkrs_pkg::STATUS_OK, 0, 0);
      add_row(rank_cmd(4, MODE_SPARE), 1'b0, mkrs_pkg::STATUS_OK, 0, 0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n])
         offer(directed_rows[n].cmd, directed_rows[n].typed, directed_rows[n].reply);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // long receiver stall up front so the output register fills and req backs up
         if (n == 0) hold_request = 1'b1;
         if (n == 300) quiet = 1'b1;
         if (n == 500) quiet = 1'b0;
         offer(random_command(), 1'b0, '0);
         if (n == 700) begin
            req_tvalid <= 1'b0;
            while (pending_replies.size() != 0) @(posedge clock);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (32) @(posedge clock);
      if (mismatches == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
